// ===== src/segment_intersection_test_defines.svh =====
// Assertion macros shared by the RTL of the segment intersection test.
// Both macros sample on the rising edge of clk and are disabled in reset.
`ifndef SEGMENT_INTERSECTION_TEST_DEFINES_SVH
`define SEGMENT_INTERSECTION_TEST_DEFINES_SVH

`ifndef SYNTHESIS

`define SEGX_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("segment intersection test: same-cycle check failed");

`define SEGX_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("segment intersection test: next-cycle check failed");

`else

`define SEGX_ASSERT_SAME(label, ante, cons)

`define SEGX_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== src/segx_pkg.sv =====
`default_nettype none

package segx_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int LIMIT_W        = 17;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1);

    typedef enum logic [1:0] {
        CASE_CROSS      = 2'd0,
        CASE_APART      = 2'd1,
        CASE_COLLINEAR  = 2'd2,
        CASE_DEGENERATE = 2'd3
    } case_code_t;

    typedef struct packed {
        logic       hit;
        case_code_t code;
    } seg_result_t;

endpackage

`default_nettype wire

// ===== src/segx_if.sv =====
`default_nettype none

// Input channel: one pair of segments per item.
interface segx_seg_if #(
    parameter int COORD_BITS = segx_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] p1_x;
    logic signed [COORD_BITS-1:0] p1_y;
    logic signed [COORD_BITS-1:0] p2_x;
    logic signed [COORD_BITS-1:0] p2_y;
    logic signed [COORD_BITS-1:0] q1_x;
    logic signed [COORD_BITS-1:0] q1_y;
    logic signed [COORD_BITS-1:0] q2_x;
    logic signed [COORD_BITS-1:0] q2_y;

    modport source (
        output valid, p1_x, p1_y, p2_x, p2_y, q1_x, q1_y, q2_x, q2_y,
        input  ready
    );
    modport sink (
        input  valid, p1_x, p1_y, p2_x, p2_y, q1_x, q1_y, q2_x, q2_y,
        output ready
    );
endinterface

// Result channel: one verdict per item.
interface segx_res_if;
    logic       valid;
    logic       ready;
    logic       hit;
    logic [1:0] case_code;

    modport source (output valid, hit, case_code, input ready);
    modport sink (input valid, hit, case_code, output ready);
endinterface

`default_nettype wire

// ===== src/segx_core.sv =====
`default_nettype none

module segx_core #(
    parameter int COORD_BITS = segx_pkg::COORD_BITS_DEF
) (
    input  logic signed [COORD_BITS-1:0]      p1_x,
    input  logic signed [COORD_BITS-1:0]      p1_y,
    input  logic signed [COORD_BITS-1:0]      p2_x,
    input  logic signed [COORD_BITS-1:0]      p2_y,
    input  logic signed [COORD_BITS-1:0]      q1_x,
    input  logic signed [COORD_BITS-1:0]      q1_y,
    input  logic signed [COORD_BITS-1:0]      q2_x,
    input  logic signed [COORD_BITS-1:0]      q2_y,
    input  logic [segx_pkg::LIMIT_W-1:0]      limit,
    output segx_pkg::seg_result_t             res
);
    import segx_pkg::*;

    // Differences need one extra bit, products twice that, and the sums of
    // two products one more; one spare bit keeps the negated limit in range.
    localparam int DW = COORD_BITS + 1;
    localparam int MW = 2 * DW;
    localparam int PW = MW + 2;

    logic signed [DW-1:0] rx, ry, sx, sy, dx, dy, ex, ey;
    logic signed [MW-1:0] rx_sy, ry_sx, dx_ry, dy_rx, dx_sy, dy_sx;
    logic signed [MW-1:0] rx_rx, ry_ry, dx_rx, dy_ry, ex_rx, ey_ry;
    logic signed [PW-1:0] rxs, dxr, dxs, rr, dot_a, dot_b, lo, hi, lim_s;

    function automatic logic near_zero(input logic signed [PW-1:0] v,
                                       input logic signed [PW-1:0] lim);
        return (v < lim) && (v > -lim);
    endfunction

    // True when num / den lies in [0, 1] for a nonzero den.
    function automatic logic in_unit(input logic signed [PW-1:0] num,
                                     input logic signed [PW-1:0] den);
        logic pos;
        pos = den > PW'(0);
        if (pos)
            return (num >= PW'(0)) && (num <= den);
        return (num <= PW'(0)) && (num >= den);
    endfunction

    assign rx = DW'(p2_x) - DW'(p1_x);
    assign ry = DW'(p2_y) - DW'(p1_y);
    assign sx = DW'(q2_x) - DW'(q1_x);
    assign sy = DW'(q2_y) - DW'(q1_y);
    assign dx = DW'(q1_x) - DW'(p1_x);
    assign dy = DW'(q1_y) - DW'(p1_y);
    assign ex = DW'(q2_x) - DW'(p1_x);
    assign ey = DW'(q2_y) - DW'(p1_y);

    assign rx_sy = rx * sy;
    assign ry_sx = ry * sx;
    assign dx_ry = dx * ry;
    assign dy_rx = dy * rx;
    assign dx_sy = dx * sy;
    assign dy_sx = dy * sx;
    assign rx_rx = rx * rx;
    assign ry_ry = ry * ry;
    assign dx_rx = dx * rx;
    assign dy_ry = dy * ry;
    assign ex_rx = ex * rx;
    assign ey_ry = ey * ry;

    assign rxs   = PW'(rx_sy) - PW'(ry_sx);
    assign dxr   = PW'(dx_ry) - PW'(dy_rx);
    assign dxs   = PW'(dx_sy) - PW'(dy_sx);
    assign rr    = PW'(rx_rx) + PW'(ry_ry);
    assign dot_a = PW'(dx_rx) + PW'(dy_ry);
    assign dot_b = PW'(ex_rx) + PW'(ey_ry);
    assign lo    = (dot_a < dot_b) ? dot_a : dot_b;
    assign hi    = (dot_a < dot_b) ? dot_b : dot_a;
    assign lim_s = PW'($signed({1'b0, limit}));

    always_comb
    begin
        res.hit  = 1'b0;
        res.code = CASE_CROSS;
        if (near_zero(rxs, lim_s))
        begin
            if (near_zero(dxr, lim_s))
            begin
                if (rr < lim_s)
                begin
                    res.code = CASE_DEGENERATE;
                end
                else
                begin
                    res.code = CASE_COLLINEAR;
                    res.hit  = (lo <= rr) && (hi >= PW'(0));
                end
            end
            else
            begin
                res.code = CASE_APART;
            end
        end
        else if (rxs != PW'(0))
        begin
            res.hit = in_unit(dxs, rxs) && in_unit(dxr, rxs);
        end
    end

endmodule

`default_nettype wire

// ===== src/segment_intersection_test.sv =====
// Channel    Modport  Payload
// seg_in     sink     p1_x p1_y p2_x p2_y q1_x q1_y q2_x q2_y (COORD_BITS, signed)
// result     source   hit (1 bit), case_code (2 bits)
// cfg        write    cfg_wr_en, cfg_wr_data (near-zero limit, 17 bits)
//
// An accepted item is first held in the input register, then the
// difference, product and compare logic loads the result register.
// One item is accepted per cycle, set by the two register stages; a
// stall on result fills both stages before seg_in.ready drops.
// rst_n clears both valid flags and sets the limit to 1.
`default_nettype none
`include "segment_intersection_test_defines.svh"

module segment_intersection_test #(
    parameter int COORD_BITS = segx_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [segx_pkg::LIMIT_W-1:0]  cfg_wr_data,
    segx_seg_if.sink                      seg_in,
    segx_res_if.source                    result
);
    import segx_pkg::*;

    logic [LIMIT_W-1:0]           limit_reg;
    logic                         s1_valid_reg, s1_valid_next;
    logic                         out_valid_reg, out_valid_next;
    seg_result_t                  out_res_reg;
    seg_result_t                  core_res;
    logic signed [COORD_BITS-1:0] p1_x_reg, p1_y_reg, p2_x_reg, p2_y_reg;
    logic signed [COORD_BITS-1:0] q1_x_reg, q1_y_reg, q2_x_reg, q2_y_reg;
    logic                         out_ready;
    logic                         s1_ready;

    assign out_ready    = !out_valid_reg || result.ready;
    assign s1_ready     = !s1_valid_reg || out_ready;
    assign seg_in.ready = s1_ready;

    always_comb
    begin
        s1_valid_next  = s1_ready ? seg_in.valid : s1_valid_reg;
        out_valid_next = out_ready ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                limit_reg <= cfg_wr_data;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && seg_in.valid)
        begin
            p1_x_reg <= seg_in.p1_x;
            p1_y_reg <= seg_in.p1_y;
            p2_x_reg <= seg_in.p2_x;
            p2_y_reg <= seg_in.p2_y;
            q1_x_reg <= seg_in.q1_x;
            q1_y_reg <= seg_in.q1_y;
            q2_x_reg <= seg_in.q2_x;
            q2_y_reg <= seg_in.q2_y;
        end
        if (out_ready && s1_valid_reg)
            out_res_reg <= core_res;
    end

    segx_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .p1_x  (p1_x_reg),
        .p1_y  (p1_y_reg),
        .p2_x  (p2_x_reg),
        .p2_y  (p2_y_reg),
        .q1_x  (q1_x_reg),
        .q1_y  (q1_y_reg),
        .q2_x  (q2_x_reg),
        .q2_y  (q2_y_reg),
        .limit (limit_reg),
        .res   (core_res)
    );

    assign result.valid     = out_valid_reg;
    assign result.hit       = out_res_reg.hit;
    assign result.case_code = out_res_reg.code;

    // Input backpressure only appears when both stages hold an item.
    `SEGX_ASSERT_SAME(a_ready_only_when_full, !seg_in.ready,
        s1_valid_reg && out_valid_reg && !result.ready)
    // An accepted item always lands in the input stage.
    `SEGX_ASSERT_NEXT(a_accept_fills_stage, seg_in.valid && seg_in.ready, s1_valid_reg)
    // A stalled input stage keeps its segment pair.
    `SEGX_ASSERT_NEXT(a_stage_holds, s1_valid_reg && !out_ready,
        s1_valid_reg && $stable(p1_x_reg) && $stable(q2_y_reg))
    // Only the crossing and collinear branches can report contact.
    `SEGX_ASSERT_SAME(a_hit_branch, result.valid && result.hit,
        result.case_code == CASE_CROSS || result.case_code == CASE_COLLINEAR)

endmodule

`default_nettype wire

// ===== tb/segment_intersection_test_tb.sv =====
`timescale 1ns / 1ps

module segment_intersection_test_tb;

    import segx_pkg::*;

    localparam int CW = COORD_BITS_DEF;
    // Wide enough for any exact cross or dot product of two differences.
    localparam int PW = 2 * CW + 4;
    localparam int RANDOM_PER_LIMIT = 275;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic signed [CW-1:0] p1_x;
        logic signed [CW-1:0] p1_y;
        logic signed [CW-1:0] p2_x;
        logic signed [CW-1:0] p2_y;
        logic signed [CW-1:0] q1_x;
        logic signed [CW-1:0] q1_y;
        logic signed [CW-1:0] q2_x;
        logic signed [CW-1:0] q2_y;
    } seg_pair_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [LIMIT_W-1:0] cfg_wr_data;

    segx_seg_if #(.COORD_BITS(CW)) seg_if ();
    segx_res_if res_if ();

    segment_intersection_test #(.COORD_BITS(CW)) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .seg_in      (seg_if),
        .result      (res_if)
    );

    logic [LIMIT_W-1:0] near_zero_limit_q;
    seg_result_t verdicts_due[$];
    seg_result_t due;
    bit steady;
    int error_count;
    int pairs_sent;
    int verdicts_checked;
    int hits_seen;
    int limits_loaded;
    int code_seen [4];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit below_limit(logic signed [PW-1:0] v);
        logic signed [PW-1:0] mag;
        mag = (v < 0) ? -v : v;
        return mag < $signed({1'b0, near_zero_limit_q});
    endfunction

    // t and u are checked as num/den in [0,1] without dividing.
    function automatic bit ratio_in_unit(logic signed [PW-1:0] num,
                                         logic signed [PW-1:0] den);
        if (den > 0)
            return (num >= 0) && (num <= den);
        return (num <= 0) && (num >= den);
    endfunction

    function automatic seg_result_t judge_pair(seg_pair_t sp);
        logic signed [CW:0] rx, ry, sx, sy, dx, dy, ex, ey;
        logic signed [PW-1:0] rxs, dxr, dxs, rr, proj_a, proj_b, lo, hi;
        seg_result_t v;
        rx = sp.p2_x - sp.p1_x;
        ry = sp.p2_y - sp.p1_y;
        sx = sp.q2_x - sp.q1_x;
        sy = sp.q2_y - sp.q1_y;
        dx = sp.q1_x - sp.p1_x;
        dy = sp.q1_y - sp.p1_y;
        ex = sp.q2_x - sp.p1_x;
        ey = sp.q2_y - sp.p1_y;
        rxs = rx * sy - ry * sx;
        dxr = dx * ry - dy * rx;
        v.hit = 1'b0;
        v.code = CASE_CROSS;
        if (below_limit(rxs)) begin
            if (below_limit(dxr)) begin
                rr = rx * rx + ry * ry;
                if (below_limit(rr)) begin
                    v.code = CASE_DEGENERATE;
                end
                else begin
                    proj_a = dx * rx + dy * ry;
                    proj_b = ex * rx + ey * ry;
                    lo = (proj_a < proj_b) ? proj_a : proj_b;
                    hi = (proj_a < proj_b) ? proj_b : proj_a;
                    v.code = CASE_COLLINEAR;
                    v.hit = (lo <= rr) && (hi >= 0);
                end
            end
            else begin
                v.code = CASE_APART;
            end
        end
        else if (rxs != 0) begin
            dxs = dx * sy - dy * sx;
            v.hit = ratio_in_unit(dxs, rxs) && ratio_in_unit(dxr, rxs);
        end
        return v;
    endfunction

    function automatic seg_pair_t pair_of(int ax, int ay, int bx, int by,
                                          int cx, int cy, int ex, int ey);
        seg_pair_t sp;
        sp.p1_x = CW'(ax);
        sp.p1_y = CW'(ay);
        sp.p2_x = CW'(bx);
        sp.p2_y = CW'(by);
        sp.q1_x = CW'(cx);
        sp.q1_y = CW'(cy);
        sp.q2_x = CW'(ex);
        sp.q2_y = CW'(ey);
        return sp;
    endfunction

    function automatic int jitter(int spread);
        return int'($urandom_range(2 * spread)) - spread;
    endfunction

    function automatic seg_pair_t random_pair();
        int c [8];
        int kind, bx, by, ux, uy, ox, oy, ta, tb, tc, j;
        kind = $urandom_range(99);
        bx = jitter(30000);
        by = jitter(30000);
        if (kind < 25) begin
            for (j = 0; j < 8; j++)
                c[j] = int'($urandom_range(65535)) - 32768;
        end
        else if (kind < 45) begin
            for (j = 0; j < 8; j += 2) begin
                c[j] = bx + jitter(64);
                c[j + 1] = by + jitter(64);
            end
        end
        else if (kind < 75) begin
            // Points along one direction, with each offset of the second segment
            // zero half of the time.
            bx = jitter(2000);
            by = jitter(2000);
            ux = jitter(8);
            uy = jitter(8);
            ta = jitter(40);
            tb = jitter(40);
            tc = jitter(40);
            ox = ($urandom_range(1) == 0) ? 0 : jitter(16);
            oy = ($urandom_range(1) == 0) ? 0 : jitter(16);
            c[0] = bx;
            c[1] = by;
            c[2] = bx + ta * ux;
            c[3] = by + ta * uy;
            c[4] = bx + tb * ux + ox;
            c[5] = by + tb * uy + oy;
            c[6] = bx + tc * ux + ox;
            c[7] = by + tc * uy + oy;
        end
        else if (kind < 85) begin
            c[0] = bx;
            c[1] = by;
            c[2] = bx;
            c[3] = by;
            for (j = 4; j < 8; j += 2) begin
                c[j] = bx + jitter(64);
                c[j + 1] = by + jitter(64);
            end
        end
        else begin
            for (j = 0; j < 8; j += 2) begin
                c[j] = bx + jitter(64);
                c[j + 1] = by + jitter(64);
            end
            j = ($urandom_range(1) == 0) ? 0 : 2;
            if ($urandom_range(1) == 0) begin
                c[4] = c[j];
                c[5] = c[j + 1];
            end
            else begin
                c[6] = c[j];
                c[7] = c[j + 1];
            end
        end
        return pair_of(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
    endfunction

    // Returns in the time step of acceptance with valid still high, so the
    // next call drives valid exactly once in that step.
    task automatic offer_pair(seg_pair_t sp);
        while (!steady && $urandom_range(99) < 22) begin
            seg_if.valid <= 1'b0;
            @(posedge clk);
        end
        seg_if.valid <= 1'b1;
        seg_if.p1_x <= sp.p1_x;
        seg_if.p1_y <= sp.p1_y;
        seg_if.p2_x <= sp.p2_x;
        seg_if.p2_y <= sp.p2_y;
        seg_if.q1_x <= sp.q1_x;
        seg_if.q1_y <= sp.q1_y;
        seg_if.q2_x <= sp.q2_x;
        seg_if.q2_y <= sp.q2_y;
        @(posedge clk);
        while (!seg_if.ready)
            @(posedge clk);
        verdicts_due.push_back(judge_pair(sp));
        pairs_sent++;
    endtask

    task automatic load_limit(logic [LIMIT_W-1:0] value);
        seg_if.valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        near_zero_limit_q = value;
        limits_loaded++;
    endtask

    task automatic test_crossings();
        offer_pair(pair_of(0, 0, 160, 160, 0, 160, 160, 0));
        offer_pair(pair_of(0, 0, 160, 160, 160, 0, 0, 160));
        offer_pair(pair_of(0, 0, 16, 16, 64, 0, 64, -100));
        offer_pair(pair_of(0, 0, 32, 0, 32, -16, 32, 16));
        offer_pair(pair_of(0, 0, 32, 0, 0, 0, 0, 32));
        offer_pair(pair_of(-100, -50, -20, -50, -60, -80, -60, -10));
    endtask

    task automatic test_parallel_and_degenerate();
        offer_pair(pair_of(0, 0, 32, 0, 0, 16, 32, 16));
        offer_pair(pair_of(0, 0, 32, 0, 16, 0, 64, 0));
        offer_pair(pair_of(0, 0, 32, 0, 48, 0, 64, 0));
        offer_pair(pair_of(0, 0, 32, 0, 32, 0, 64, 0));
        offer_pair(pair_of(0, 0, 32, 0, 80, 0, -80, 0));
        offer_pair(pair_of(0, 0, 32, 0, -64, 0, -1, 0));
        offer_pair(pair_of(5, 5, 5, 5, 0, 0, 10, 10));
        offer_pair(pair_of(0, 0, 32, 0, 8, 0, 8, 0));
        offer_pair(pair_of(7, -3, 7, -3, 7, -3, 7, -3));
    endtask

    task automatic test_coordinate_extremes();
        offer_pair(pair_of(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        offer_pair(pair_of(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        offer_pair(pair_of(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
        offer_pair(pair_of(-32768, 0, 32767, 0, -32768, 0, 32767, 0));
        offer_pair(pair_of(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768));
    endtask

    // With a zero limit nothing is small, so parallel pairs fall through
    // to the crossing test and report no contact on an exactly zero cross
    // product.
    task automatic test_zero_limit();
        load_limit('0);
        offer_pair(pair_of(0, 0, 32, 0, 0, 16, 32, 16));
        offer_pair(pair_of(0, 0, 32, 0, 16, 0, 64, 0));
        offer_pair(pair_of(3, 3, 3, 3, 0, 0, 10, 10));
    endtask

    task automatic test_wide_limit();
        load_limit(LIMIT_W'(65536));
        offer_pair(pair_of(0, 0, 256, 0, 0, 16, 256, 17));
        offer_pair(pair_of(0, 0, 16, 0, 4, 0, 40, 0));
    endtask

    task automatic test_random_sweep();
        logic [LIMIT_W-1:0] limits [6];
        int k, i;
        limits = '{LIMIT_RESET, LIMIT_W'(65536), LIMIT_W'(16), LIMIT_W'(0),
                   LIMIT_W'(131071), LIMIT_W'(4096)};
        for (k = 0; k < 6; k++) begin
            load_limit(limits[k]);
            // One phase runs with both sides at full rate.
            steady = (k == 2);
            for (i = 0; i < RANDOM_PER_LIMIT; i++)
                offer_pair(random_pair());
        end
        steady = 1'b0;
    endtask

    always @(posedge clk)
        res_if.ready <= steady || ($urandom_range(99) >= 22);

    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready) begin
            if (verdicts_due.size() == 0) begin
                $error("result item with no pair outstanding");
                error_count++;
            end
            else begin
                due = verdicts_due.pop_front();
                if (res_if.hit !== due.hit) begin
                    $error("hit: expected %0b, got %0b", due.hit, res_if.hit);
                    error_count++;
                end
                if (res_if.case_code !== due.code) begin
                    $error("case_code: expected %0d, got %0d", due.code, res_if.case_code);
                    error_count++;
                end
                verdicts_checked++;
                hits_seen += due.hit;
                code_seen[due.code]++;
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((seg_if.valid && seg_if.ready) || (res_if.valid && res_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("segment_intersection_test_tb failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        seg_if.valid = 1'b0;
        seg_if.p1_x = '0;
        seg_if.p1_y = '0;
        seg_if.p2_x = '0;
        seg_if.p2_y = '0;
        seg_if.q1_x = '0;
        seg_if.q1_y = '0;
        seg_if.q2_x = '0;
        seg_if.q2_y = '0;
        near_zero_limit_q = LIMIT_RESET;
        steady = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_crossings();
        test_parallel_and_degenerate();
        test_coordinate_extremes();
        test_zero_limit();
        test_wide_limit();
        test_random_sweep();

        seg_if.valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (verdicts_due.size() != 0)
            error_count++;

        $display("Checked %0d of %0d segment pairs under %0d limit loads, %0d of them hits.",
                 verdicts_checked, pairs_sent, limits_loaded, hits_seen);
        $display("Verdicts: %0d crossing, %0d parallel apart, %0d collinear, %0d degenerate.",
                 code_seen[CASE_CROSS], code_seen[CASE_APART],
                 code_seen[CASE_COLLINEAR], code_seen[CASE_DEGENERATE]);
        if (error_count == 0)
            $display("segment_intersection_test_tb passed");
        else
            $display("segment_intersection_test_tb failed");
        $finish;
    end

endmodule
